/* design/thnr_pkg.sv */
// thnr_pkg: shared types and constants of the two-hop neighbor recommend unit
// depends on nothing; used by the top level and its checker
`default_nettype none

package thnr_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_DEGREE_DEF   = 16;

    localparam int VERTEX_W = 6;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

    typedef enum logic {
        ACT_ADD_EDGE = 1'b0,
        ACT_QUERY    = 1'b1
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_STORED    = 2'd0,
        STATUS_REJECT    = 2'd1,
        STATUS_RECOMMEND = 2'd2,
        STATUS_NONE      = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CHECK,
        ST_CLEAR,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_NB_RD,
        ST_NB_WAIT,
        ST_FCNT,
        ST_G_RD,
        ST_G_SEEN,
        ST_G_TEST,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

/* design/thnr_ram.sv */
// thnr_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
`default_nettype none

module thnr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* design/two_hop_neighbor_recommend_unit.sv */
// two_hop_neighbor_recommend_unit: adjacency store with friends-of-friends query
// depends on thnr_pkg and thnr_ram
//
// Input channel s_*: one transfer carries an action. An add-edge appends the
// target to the source's slot list and gives one result (stored or rejected).
// A query gives one result per vertex two hops from the person, in list
// order, last set on the final one; a single "none" result if there are none,
// a single reject if the person is out of range.
// cfg_* channel writes vertex_count; it is taken at any time, intended idle.
// Results leave through the m_* output register. A new input transfer is
// taken while the last result still waits in that register.
// A query clears the visited bitmap, marks the direct neighbors of the person,
// then reads each direct neighbor's count and walks that neighbor's slot list
// in turn; each memory has a single ram read port. After reset the count ram
// is cleared entry by entry with s_ready low. A stalled receiver stops the
// walk at the next result that needs the output register; nothing is lost.
`default_nettype none

module two_hop_neighbor_recommend_unit #(
    parameter int MAX_VERTICES = thnr_pkg::MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = thnr_pkg::MAX_DEGREE_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_action,
    input  wire logic [thnr_pkg::VERTEX_W-1:0] s_source_vertex,
    input  wire logic [thnr_pkg::VERTEX_W-1:0] s_target_vertex,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [thnr_pkg::STATUS_W-1:0] m_status,
    output logic      [thnr_pkg::VERTEX_W-1:0] m_recommended_vertex,
    output logic                               m_last,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [thnr_pkg::COUNT_W-1:0]  cfg_vertex_count
);

    localparam int VID_W  = $clog2(MAX_VERTICES);
    localparam int ADDR_W = $clog2(MAX_VERTICES * MAX_DEGREE);
    localparam int CNT_W  = $clog2(MAX_DEGREE + 1);
    localparam int NW     = (VID_W + 1 > thnr_pkg::COUNT_W) ? VID_W + 1 : thnr_pkg::COUNT_W;
    localparam logic [NW-1:0]     MV_N   = NW'(MAX_VERTICES);
    localparam logic [ADDR_W-1:0] DEG_A  = ADDR_W'(MAX_DEGREE);
    localparam logic [CNT_W-1:0]  DEG_C  = CNT_W'(MAX_DEGREE);
    localparam logic [VID_W-1:0]  LAST_V = VID_W'(MAX_VERTICES - 1);

    thnr_pkg::state_t state_reg, state_next;

    logic [thnr_pkg::COUNT_W-1:0]  vertex_count_reg;
    logic [VID_W-1:0]              clr_idx_reg, clr_idx_next;
    logic                          action_reg, action_next;
    logic [thnr_pkg::VERTEX_W-1:0] src_reg, src_next;
    logic [thnr_pkg::VERTEX_W-1:0] dst_reg, dst_next;
    logic [ADDR_W-1:0]             src_base_reg, src_base_next;
    logic [ADDR_W-1:0]             f_base_reg, f_base_next;
    logic [CNT_W-1:0]              my_cnt_reg, my_cnt_next;
    logic [CNT_W-1:0]              fcnt_reg, fcnt_next;
    logic [CNT_W-1:0]              a_reg, a_next;
    logic [CNT_W-1:0]              b_reg, b_next;
    logic [VID_W-1:0]              g_reg, g_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [VID_W-1:0]              pend_reg, pend_next;

    logic                          m_valid_reg, m_valid_next;
    logic [thnr_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [thnr_pkg::VERTEX_W-1:0] m_vertex_reg, m_vertex_next;
    logic                          m_last_reg, m_last_next;

    logic              slot_we;
    logic [ADDR_W-1:0] slot_waddr, slot_raddr;
    logic [VID_W-1:0]  slot_wdata, slot_rdata;
    logic              cnt_we;
    logic [VID_W-1:0]  cnt_waddr, cnt_raddr;
    logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;
    logic              seen_we;
    logic [VID_W-1:0]  seen_waddr, seen_raddr;
    logic              seen_wdata, seen_rdata;

    logic              s_fire, out_free, out_load;
    logic [NW-1:0]     active_n;
    logic              src_ok, dst_ok, list_full, is_query;
    logic [VID_W-1:0]  src_v;

    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign active_n  = (NW'(vertex_count_reg) < MV_N) ? NW'(vertex_count_reg) : MV_N;
    assign src_ok    = NW'(src_reg) < active_n;
    assign dst_ok    = NW'(dst_reg) < active_n;
    assign list_full = cnt_rdata >= DEG_C;
    assign is_query  = action_reg == thnr_pkg::ACT_QUERY;
    assign src_v     = VID_W'(src_reg);

    assign s_ready              = state_reg == thnr_pkg::ST_IDLE;
    assign cfg_ready            = 1'b1;
    assign m_valid              = m_valid_reg;
    assign m_status             = m_status_reg;
    assign m_recommended_vertex = m_vertex_reg;
    assign m_last               = m_last_reg;

    thnr_ram #(.WIDTH(VID_W), .DEPTH(MAX_VERTICES * MAX_DEGREE)) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    thnr_ram #(.WIDTH(CNT_W), .DEPTH(MAX_VERTICES)) u_cnt_ram (
        .aclk  (aclk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    thnr_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_seen_ram (
        .aclk  (aclk),
        .we    (seen_we),
        .waddr (seen_waddr),
        .wdata (seen_wdata),
        .raddr (seen_raddr),
        .rdata (seen_rdata)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            thnr_pkg::ST_INIT: begin
                if (clr_idx_reg == LAST_V) begin
                    state_next = thnr_pkg::ST_IDLE;
                end
            end
            thnr_pkg::ST_IDLE: begin
                if (s_fire) begin
                    state_next = thnr_pkg::ST_CHECK;
                end
            end
            thnr_pkg::ST_CHECK: begin
                if (is_query && src_ok) begin
                    state_next = thnr_pkg::ST_CLEAR;
                end else if (out_free) begin
                    state_next = thnr_pkg::ST_IDLE;
                end
            end
            thnr_pkg::ST_CLEAR: begin
                if (clr_idx_reg == LAST_V) begin
                    state_next = thnr_pkg::ST_MARK_RD;
                end
            end
            thnr_pkg::ST_MARK_RD: begin
                if (a_reg == my_cnt_reg) begin
                    state_next = thnr_pkg::ST_NB_RD;
                end else begin
                    state_next = thnr_pkg::ST_MARK_WR;
                end
            end
            thnr_pkg::ST_MARK_WR: begin
                state_next = thnr_pkg::ST_MARK_RD;
            end
            thnr_pkg::ST_NB_RD: begin
                if (a_reg == my_cnt_reg) begin
                    state_next = thnr_pkg::ST_FINISH;
                end else begin
                    state_next = thnr_pkg::ST_NB_WAIT;
                end
            end
            thnr_pkg::ST_NB_WAIT: begin
                state_next = thnr_pkg::ST_FCNT;
            end
            thnr_pkg::ST_FCNT: begin
                state_next = thnr_pkg::ST_G_RD;
            end
            thnr_pkg::ST_G_RD: begin
                if (b_reg == fcnt_reg) begin
                    state_next = thnr_pkg::ST_NB_RD;
                end else begin
                    state_next = thnr_pkg::ST_G_SEEN;
                end
            end
            thnr_pkg::ST_G_SEEN: begin
                state_next = thnr_pkg::ST_G_TEST;
            end
            thnr_pkg::ST_G_TEST: begin
                if (seen_rdata || !pend_valid_reg || out_free) begin
                    state_next = thnr_pkg::ST_G_RD;
                end
            end
            thnr_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = thnr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = thnr_pkg::ST_INIT;
            end
        endcase
    end

    // datapath, memory ports and result loading
    always_comb begin
        logic [ADDR_W-1:0] base_sel;
        logic [CNT_W-1:0]  idx_sel;

        base_sel        = src_base_reg;
        idx_sel         = a_reg;
        clr_idx_next    = clr_idx_reg;
        action_next     = action_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        src_base_next   = src_base_reg;
        f_base_next     = f_base_reg;
        my_cnt_next     = my_cnt_reg;
        fcnt_next       = fcnt_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        g_next          = g_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;

        slot_we    = 1'b0;
        slot_waddr = src_base_reg + ADDR_W'(cnt_rdata);
        slot_wdata = VID_W'(dst_reg);
        cnt_we     = 1'b0;
        cnt_waddr  = src_v;
        cnt_wdata  = CNT_W'(cnt_rdata + 1'b1);
        cnt_raddr  = src_v;
        seen_we    = 1'b0;
        seen_waddr = slot_rdata;
        seen_wdata = 1'b1;
        seen_raddr = g_reg;

        out_load      = 1'b0;
        m_status_next = m_status_reg;
        m_vertex_next = m_vertex_reg;
        m_last_next   = m_last_reg;

        case (state_reg)
            thnr_pkg::ST_INIT: begin
                cnt_we       = 1'b1;
                cnt_waddr    = clr_idx_reg;
                cnt_wdata    = '0;
                clr_idx_next = (clr_idx_reg == LAST_V) ? '0 : clr_idx_reg + 1'b1;
            end
            thnr_pkg::ST_IDLE: begin
                cnt_raddr = VID_W'(s_source_vertex);
                if (s_fire) begin
                    action_next   = s_action;
                    src_next      = s_source_vertex;
                    dst_next      = s_target_vertex;
                    src_base_next = ADDR_W'(VID_W'(s_source_vertex)) * DEG_A;
                end
            end
            thnr_pkg::ST_CHECK: begin
                if (is_query && src_ok) begin
                    my_cnt_next  = cnt_rdata;
                    clr_idx_next = '0;
                end else if (out_free) begin
                    out_load      = 1'b1;
                    m_vertex_next = '0;
                    m_last_next   = 1'b1;
                    if (is_query || !src_ok || !dst_ok || list_full) begin
                        m_status_next = thnr_pkg::STATUS_REJECT;
                    end else begin
                        m_status_next = thnr_pkg::STATUS_STORED;
                        slot_we       = 1'b1;
                        cnt_we        = 1'b1;
                    end
                end
            end
            thnr_pkg::ST_CLEAR: begin
                // the person itself is marked as its entry is cleared
                seen_we      = 1'b1;
                seen_waddr   = clr_idx_reg;
                seen_wdata   = clr_idx_reg == src_v;
                clr_idx_next = (clr_idx_reg == LAST_V) ? '0 : clr_idx_reg + 1'b1;
                a_next       = '0;
            end
            thnr_pkg::ST_MARK_RD: begin
                if (a_reg == my_cnt_reg) begin
                    a_next = '0;
                end
            end
            thnr_pkg::ST_MARK_WR: begin
                seen_we = 1'b1;
                a_next  = a_reg + 1'b1;
            end
            thnr_pkg::ST_NB_WAIT: begin
                f_base_next = ADDR_W'(slot_rdata) * DEG_A;
                cnt_raddr   = slot_rdata;
            end
            thnr_pkg::ST_FCNT: begin
                fcnt_next = cnt_rdata;
                b_next    = '0;
            end
            thnr_pkg::ST_G_RD: begin
                base_sel = f_base_reg;
                idx_sel  = b_reg;
                if (b_reg == fcnt_reg) begin
                    a_next = a_reg + 1'b1;
                end
            end
            thnr_pkg::ST_G_SEEN: begin
                g_next     = slot_rdata;
                seen_raddr = slot_rdata;
            end
            thnr_pkg::ST_G_TEST: begin
                if (seen_rdata) begin
                    b_next = b_reg + 1'b1;
                end else if (!pend_valid_reg || out_free) begin
                    // hold back one result so last can be set on the final one
                    seen_we    = 1'b1;
                    seen_waddr = g_reg;
                    if (pend_valid_reg) begin
                        out_load      = 1'b1;
                        m_status_next = thnr_pkg::STATUS_RECOMMEND;
                        m_vertex_next = thnr_pkg::VERTEX_W'(pend_reg);
                        m_last_next   = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_next       = g_reg;
                    b_next          = b_reg + 1'b1;
                end
            end
            thnr_pkg::ST_FINISH: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    if (pend_valid_reg) begin
                        m_status_next = thnr_pkg::STATUS_RECOMMEND;
                        m_vertex_next = thnr_pkg::VERTEX_W'(pend_reg);
                    end else begin
                        m_status_next = thnr_pkg::STATUS_NONE;
                        m_vertex_next = '0;
                    end
                end
            end
            default: begin
            end
        endcase

        // one address adder shared by every slot read
        slot_raddr = base_sel + ADDR_W'(idx_sel);

        m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= thnr_pkg::ST_INIT;
            clr_idx_reg      <= '0;
            vertex_count_reg <= thnr_pkg::VERTEX_COUNT_RESET;
            pend_valid_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                vertex_count_reg <= cfg_vertex_count;
            end
        end
    end

    always_ff @(posedge aclk) begin
        action_reg   <= action_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        src_base_reg <= src_base_next;
        f_base_reg   <= f_base_next;
        my_cnt_reg   <= my_cnt_next;
        fcnt_reg     <= fcnt_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        g_reg        <= g_next;
        pend_reg     <= pend_next;
        m_status_reg <= m_status_next;
        m_vertex_reg <= m_vertex_next;
        m_last_reg   <= m_last_next;
    end

endmodule

`default_nettype wire

/* design/thnr_checker.sv */
// thnr_checker: port-level assertions for two_hop_neighbor_recommend_unit
// depends on thnr_pkg; bound to the top level at the end of this file
`default_nettype none

module thnr_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [thnr_pkg::STATUS_W-1:0] m_status,
    input wire logic [thnr_pkg::VERTEX_W-1:0] m_recommended_vertex,
    input wire logic                          m_last
);

    // stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_recommended_vertex) && $stable(m_last))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("channel active right after reset");

    // single results carry vertex zero and close the item
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != thnr_pkg::STATUS_RECOMMEND
            |-> m_last && m_recommended_vertex == '0)
        else $error("single result malformed");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in progress");

endmodule

bind two_hop_neighbor_recommend_unit thnr_checker u_thnr_checker (
    .aclk                 (aclk),
    .aresetn              (aresetn),
    .s_valid              (s_valid),
    .s_ready              (s_ready),
    .m_valid              (m_valid),
    .m_ready              (m_ready),
    .m_status             (m_status),
    .m_recommended_vertex (m_recommended_vertex),
    .m_last               (m_last)
);

`default_nettype wire
